// ===== hdl/bptc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the barometric pressure / temperature compensation core
// no dependencies; imported by every module of the core

package bptc_pkg;

   // field widths
   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int TEMP_W  = 19;
   localparam int PRESS_W = 32;

   // datapath widths
   localparam int DT_W      = 25;  // raw temperature minus reference
   localparam int MUL_W     = 42;  // dT times a calibration word
   localparam int SQD_W     = 50;  // dT squared
   localparam int SQ_W      = 38;  // squared temperature deviation
   localparam int ACC_W     = 44;  // offset and sensitivity
   localparam int SENS_LO_W = 20;  // low slice of sensitivity for the split multiply
   localparam int PLO_W     = 46;  // raw pressure times low slice
   localparam int PHI_W     = 49;  // raw pressure times high slice
   localparam int PROD_W    = 64;  // raw pressure times sensitivity

   // scaling shifts
   localparam int TEMP_SHIFT  = 23;
   localparam int OFF_SHIFT   = 6;
   localparam int SENS_SHIFT  = 7;
   localparam int T2_SHIFT    = 31;
   localparam int OFF2_SHIFT  = 4;
   localparam int PRESS_SHIFT = 21;
   localparam int FINAL_SHIFT = 15;

   // temperature break points in 0.01 C
   localparam logic signed [TEMP_W-1:0] TEMP_REF      = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_VERY_LOW = -19'sd1500;

   // second-order gains
   localparam logic signed [ACC_W-1:0] OFF2_GAIN     = 44'sd61;
   localparam logic signed [ACC_W-1:0] OFF2_LOW_GAIN = 44'sd15;
   localparam logic signed [ACC_W-1:0] SENS2_GAIN    = 44'sd2;
   localparam logic signed [ACC_W-1:0] SENS2_LOW_GAIN = 44'sd8;

   // operating range limits
   localparam logic signed [PRESS_W-1:0] PRESS_MIN = 32'sd1000;
   localparam logic signed [PRESS_W-1:0] PRESS_MAX = 32'sd120000;
   localparam logic signed [TEMP_W-1:0]  TEMP_MIN  = -19'sd4000;
   localparam logic signed [TEMP_W-1:0]  TEMP_MAX  = 19'sd8500;

   // register map
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS_COEFF  = 3'd0,
      CSR_OFF_COEFF   = 3'd1,
      CSR_SENS_TEMPCO = 3'd2,
      CSR_OFF_TEMPCO  = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   // calibration words
   typedef struct packed {
      logic [CAL_W-1:0] sens_coeff;
      logic [CAL_W-1:0] off_coeff;
      logic [CAL_W-1:0] sens_tempco;
      logic [CAL_W-1:0] off_tempco;
      logic [CAL_W-1:0] ref_temp;
      logic [CAL_W-1:0] temp_slope;
   } cal_type;

   // first-order results
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [TEMP_W-1:0] t2;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [RAW_W-1:0]         d1;
   } first_type;

   // fully compensated terms
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [RAW_W-1:0]         d1;
   } comp_type;

endpackage

// ===== hdl/bptc_first.sv =====
`timescale 1ns / 1ps
// first-order terms: dT, TEMP, OFF, SENS and the T2 square, three pipeline stages
// depends on bptc_pkg

module bptc_first import bptc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cal_type          cal,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [RAW_W-1:0] in_d1,
   input  logic [RAW_W-1:0] in_d2,
   output logic             out_valid,
   input  logic             out_stall,
   output first_type        out_data
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   logic signed [DT_W-1:0] s1_dt_ff, s1_dt_in;
   logic [RAW_W-1:0]       s1_d1_ff, s2_d1_ff;

   logic signed [MUL_W-1:0] s2_slope_ff, s2_slope_in;
   logic signed [MUL_W-1:0] s2_off_ff, s2_off_in;
   logic signed [MUL_W-1:0] s2_sens_ff, s2_sens_in;
   logic signed [SQD_W-1:0] s2_sq_ff, s2_sq_in;

   first_type s3_data_ff, s3_data_in;

   // stage ready chain
   assign s3_ready = !s3_valid_ff || !out_stall;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_stall = !s1_ready;

   // stage 1: dT = D2 - C5*256
   assign s1_dt_in = $signed({1'b0, in_d2}) - $signed({1'b0, cal.ref_temp, 8'd0});

   // stage 2: products of dT
   always_comb begin
      s2_slope_in = MUL_W'(s1_dt_ff) * MUL_W'($signed({1'b0, cal.temp_slope}));
      s2_off_in   = MUL_W'(s1_dt_ff) * MUL_W'($signed({1'b0, cal.off_tempco}));
      s2_sens_in  = MUL_W'(s1_dt_ff) * MUL_W'($signed({1'b0, cal.sens_tempco}));
      s2_sq_in    = SQD_W'(s1_dt_ff) * SQD_W'(s1_dt_ff);
   end

   // stage 3: scale and add the base terms
   always_comb begin
      s3_data_in.temp = TEMP_REF + TEMP_W'(s2_slope_ff >>> TEMP_SHIFT);
      s3_data_in.off  = ACC_W'($signed({1'b0, cal.off_coeff, 17'd0}))
                        + ACC_W'(s2_off_ff >>> OFF_SHIFT);
      s3_data_in.sens = ACC_W'($signed({1'b0, cal.sens_coeff, 16'd0}))
                        + ACC_W'(s2_sens_ff >>> SENS_SHIFT);
      s3_data_in.t2   = TEMP_W'(s2_sq_ff >>> T2_SHIFT);
      s3_data_in.d1   = s2_d1_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_dt_ff <= s1_dt_in;
         s1_d1_ff <= in_d1;
      end
      if (s2_ready) begin
         s2_slope_ff <= s2_slope_in;
         s2_off_ff   <= s2_off_in;
         s2_sens_ff  <= s2_sens_in;
         s2_sq_ff    <= s2_sq_in;
         s2_d1_ff    <= s1_d1_ff;
      end
      if (s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

// ===== hdl/bptc_second.sv =====
`timescale 1ns / 1ps
// second-order corrections below 20 C and -15 C, three pipeline stages
// depends on bptc_pkg

module bptc_second import bptc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  first_type in_data,
   output logic      out_valid,
   input  logic      out_stall,
   output comp_type  out_data
);

   logic s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic s4_ready, s5_ready, s6_ready;

   logic signed [TEMP_W-1:0] s4_dtemp, s4_vl;
   logic signed [SQ_W-1:0]   s4_sq_ff, s4_sq_in, s4_sql_ff, s4_sql_in;
   logic                     s4_cold_ff, s4_cold_in, s4_frost_ff, s4_frost_in;
   first_type                s4_data_ff;

   logic signed [ACC_W-1:0]  s5_off2_ff, s5_off2_in, s5_sens2_ff, s5_sens2_in;
   logic signed [ACC_W-1:0]  s5_off_ff, s5_sens_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff, s5_temp_in;
   logic [RAW_W-1:0]         s5_d1_ff;

   comp_type s6_data_ff, s6_data_in;

   // stage ready chain
   assign s6_ready = !s6_valid_ff || !out_stall;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_stall = !s4_ready;

   // stage 4: squared deviations from 20 C and -15 C
   always_comb begin
      s4_dtemp    = in_data.temp - TEMP_REF;
      s4_vl       = in_data.temp - TEMP_VERY_LOW;
      s4_sq_in    = SQ_W'(s4_dtemp) * SQ_W'(s4_dtemp);
      s4_sql_in   = SQ_W'(s4_vl) * SQ_W'(s4_vl);
      s4_cold_in  = in_data.temp < TEMP_REF;
      s4_frost_in = in_data.temp < TEMP_VERY_LOW;
   end

   // stage 5: correction terms, zero above 20 C
   always_comb begin
      s5_off2_in  = ((ACC_W'(s4_sq_ff) * OFF2_GAIN) >>> OFF2_SHIFT)
                    + (s4_frost_ff ? ACC_W'(s4_sql_ff) * OFF2_LOW_GAIN : '0);
      s5_sens2_in = ACC_W'(s4_sq_ff) * SENS2_GAIN
                    + (s4_frost_ff ? ACC_W'(s4_sql_ff) * SENS2_LOW_GAIN : '0);
      s5_temp_in  = s4_data_ff.temp;
      if (!s4_cold_ff) begin
         s5_off2_in  = '0;
         s5_sens2_in = '0;
      end else begin
         s5_temp_in = s4_data_ff.temp - s4_data_ff.t2;
      end
   end

   // stage 6: apply corrections
   always_comb begin
      s6_data_in.temp = s5_temp_ff;
      s6_data_in.off  = s5_off_ff - s5_off2_ff;
      s6_data_in.sens = s5_sens_ff - s5_sens2_ff;
      s6_data_in.d1   = s5_d1_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) s4_valid_ff <= in_valid;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_sq_ff    <= s4_sq_in;
         s4_sql_ff   <= s4_sql_in;
         s4_cold_ff  <= s4_cold_in;
         s4_frost_ff <= s4_frost_in;
         s4_data_ff  <= in_data;
      end
      if (s5_ready) begin
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
         s5_temp_ff  <= s5_temp_in;
         s5_off_ff   <= s4_data_ff.off;
         s5_sens_ff  <= s4_data_ff.sens;
         s5_d1_ff    <= s4_data_ff.d1;
      end
      if (s6_ready) begin
         s6_data_ff <= s6_data_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_data  = s6_data_ff;

endmodule

// ===== hdl/bptc_press.sv =====
`timescale 1ns / 1ps
// pressure from raw reading, split multiply, final scaling and range check; four stages
// depends on bptc_pkg

module bptc_press import bptc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  comp_type                  in_data,
   output logic                      out_valid,
   input  logic                      out_stall,
   output logic signed [TEMP_W-1:0]  out_temp,
   output logic signed [PRESS_W-1:0] out_press,
   output logic                      out_ok
);

   logic s7_valid_ff, s8_valid_ff, s9_valid_ff, s10_valid_ff;
   logic s7_ready, s8_ready, s9_ready, s10_ready;

   logic signed [PLO_W-1:0]   s7_lo_ff, s7_lo_in;
   logic signed [PHI_W-1:0]   s7_hi_ff, s7_hi_in;
   logic signed [ACC_W-1:0]   s7_off_ff, s8_off_ff;
   logic signed [TEMP_W-1:0]  s7_temp_ff, s8_temp_ff, s9_temp_ff, s10_temp_ff;
   logic signed [PROD_W-1:0]  s8_prod_ff, s8_prod_in;
   logic signed [PROD_W-1:0]  s9_diff;
   logic signed [PRESS_W-1:0] s9_press_ff, s9_press_in, s10_press_ff;
   logic                      s10_ok_ff, s10_ok_in;

   // stage ready chain
   assign s10_ready = !s10_valid_ff || !out_stall;
   assign s9_ready  = !s9_valid_ff || s10_ready;
   assign s8_ready  = !s8_valid_ff || s9_ready;
   assign s7_ready  = !s7_valid_ff || s8_ready;
   assign in_stall  = !s7_ready;

   // stage 7: D1 times the low and high slices of SENS
   always_comb begin
      s7_lo_in = PLO_W'($signed({1'b0, in_data.d1}))
                 * PLO_W'($signed({1'b0, in_data.sens[SENS_LO_W-1:0]}));
      s7_hi_in = PHI_W'($signed({1'b0, in_data.d1}))
                 * PHI_W'($signed(in_data.sens[ACC_W-1:SENS_LO_W]));
   end

   // stage 8: merge the partial products
   assign s8_prod_in = (PROD_W'(s7_hi_ff) <<< SENS_LO_W) + PROD_W'(s7_lo_ff);

   // stage 9: remove offset and scale
   always_comb begin
      s9_diff     = (s8_prod_ff >>> PRESS_SHIFT) - PROD_W'(s8_off_ff);
      s9_press_in = PRESS_W'(s9_diff >>> FINAL_SHIFT);
   end

   // stage 10: operating range check
   assign s10_ok_in = (s9_press_ff >= PRESS_MIN) && (s9_press_ff <= PRESS_MAX)
                      && (s9_temp_ff >= TEMP_MIN) && (s9_temp_ff <= TEMP_MAX);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else begin
         if (s7_ready)  s7_valid_ff  <= in_valid;
         if (s8_ready)  s8_valid_ff  <= s7_valid_ff;
         if (s9_ready)  s9_valid_ff  <= s8_valid_ff;
         if (s10_ready) s10_valid_ff <= s9_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s7_ready) begin
         s7_lo_ff   <= s7_lo_in;
         s7_hi_ff   <= s7_hi_in;
         s7_off_ff  <= in_data.off;
         s7_temp_ff <= in_data.temp;
      end
      if (s8_ready) begin
         s8_prod_ff <= s8_prod_in;
         s8_off_ff  <= s7_off_ff;
         s8_temp_ff <= s7_temp_ff;
      end
      if (s9_ready) begin
         s9_press_ff <= s9_press_in;
         s9_temp_ff  <= s8_temp_ff;
      end
      if (s10_ready) begin
         s10_press_ff <= s9_press_ff;
         s10_temp_ff  <= s9_temp_ff;
         s10_ok_ff    <= s10_ok_in;
      end
   end

   assign out_valid = s10_valid_ff;
   assign out_temp  = s10_temp_ff;
   assign out_press = s10_press_ff;
   assign out_ok    = s10_ok_ff;

endmodule

// ===== hdl/baro_pressure_temp_compensation_core.sv =====
`timescale 1ns / 1ps
// top level of the barometric pressure / temperature compensation core
// depends on bptc_pkg, bptc_first, bptc_second, bptc_press

// Compensates one raw 24-bit pressure and temperature pair per transfer into
// temperature (0.01 C) and pressure (0.01 mbar) with second-order corrections
// below 20 C and -15 C, plus an operating range flag. The datapath is a
// ten-stage pipeline: a new pair is taken every cycle while req_stall is low. The
// stages follow the chain of multiply steps (dT products, squared deviations,
// a split 24 x 44 bit pressure multiply), each followed by a register.
// Back-pressure on the result side fills empty stages first and reaches
// req_stall only when all ten hold data. The six calibration words are
// written through the csr port, which is always ready; write them only while
// no transfer is in flight.

module baro_pressure_temp_compensation_core import bptc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [RAW_W-1:0]          req_raw_pressure,
   input  logic [RAW_W-1:0]          req_raw_temperature,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [TEMP_W-1:0]  rsp_temp_centi,
   output logic signed [PRESS_W-1:0] rsp_press_centi,
   output logic                      rsp_in_range,
   // calibration register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CAL_W-1:0]          csr_wdata
);

   cal_type   cal_ff, cal_in;
   logic      first_valid, first_stall, second_valid, second_stall;
   first_type first_data;
   comp_type  second_data;

   assign csr_ready = 1'b1;

   // calibration register write decode
   always_comb begin
      cal_in = cal_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENS_COEFF:  cal_in.sens_coeff  = csr_wdata;
            CSR_OFF_COEFF:   cal_in.off_coeff   = csr_wdata;
            CSR_SENS_TEMPCO: cal_in.sens_tempco = csr_wdata;
            CSR_OFF_TEMPCO:  cal_in.off_tempco  = csr_wdata;
            CSR_REF_TEMP:    cal_in.ref_temp    = csr_wdata;
            CSR_TEMP_SLOPE:  cal_in.temp_slope  = csr_wdata;
            default:         cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // first-order terms
   bptc_first u_first (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_d1     (req_raw_pressure),
      .in_d2     (req_raw_temperature),
      .out_valid (first_valid),
      .out_stall (first_stall),
      .out_data  (first_data)
   );

   // second-order corrections
   bptc_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_stall  (first_stall),
      .in_data   (first_data),
      .out_valid (second_valid),
      .out_stall (second_stall),
      .out_data  (second_data)
   );

   // pressure and range check
   bptc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (second_valid),
      .in_stall  (second_stall),
      .in_data   (second_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_temp  (rsp_temp_centi),
      .out_press (rsp_press_centi),
      .out_ok    (rsp_in_range)
   );

endmodule

// ===== hdl/bptc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the compensation core, bound to the top level
// depends on bptc_pkg and baro_pressure_temp_compensation_core

module bptc_checker import bptc_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [TEMP_W-1:0]  rsp_temp_centi,
   input logic signed [PRESS_W-1:0] rsp_press_centi,
   input logic                      rsp_in_range
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_centi)
         && $stable(rsp_press_centi) && $stable(rsp_in_range))
      else $error("stalled response changed");

   // range flag agrees with the values it reports on
   a_range_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |-> rsp_press_centi >= PRESS_MIN
         && rsp_press_centi <= PRESS_MAX && rsp_temp_centi >= TEMP_MIN
         && rsp_temp_centi <= TEMP_MAX)
      else $error("in_range set outside operating range");

   // request side only stalls when the response side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response back-pressure");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_bptc_checker (.*);
